// ----- hdl/vdl_pkg.sv -----
package vdl_pkg;

   // line and oscillator geometry
   localparam int LINE_DEPTH     = 1024;
   localparam int SAMPLE_RATE    = 48000;
   localparam int COS_TABLE_BITS = 10;

   localparam int ADDR_W  = $clog2(LINE_DEPTH);
   localparam int COUNT_W = $clog2(SAMPLE_RATE);

   // field and register widths
   localparam int SAMPLE_W = 16;
   localparam int DEPTH_W  = 18;
   localparam int GAIN_W   = 16;
   localparam int PHASE_W  = 32;
   localparam int WEIGHT_W = 17;
   localparam int CSR_W    = 32;
   localparam int CSR_IDX_W = 2;
   localparam int MIX_W    = 26;
   localparam int PROD_W   = 43;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEPTH    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LFO_STEP = 2'd2;

   localparam logic [GAIN_W-1:0] GAIN_RESET  = 16'd16384;
   localparam logic [31:0]       DEPTH_LIMIT = 32'((LINE_DEPTH - 1) * 256);

   // rounding constant for the Q22 product
   localparam logic signed [PROD_W-1:0] PROD_ROUND = PROD_W'(64'd1 << 21);

   // quarter-wave cosine table, Q30, indexes 0 to a quarter turn inclusive
   localparam int COS_QUARTER = 2 ** (COS_TABLE_BITS - 2);
   localparam int COS_IDX_W   = COS_TABLE_BITS - 1;
   localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
   localparam logic [63:0] ONE_Q30    = 64'd1 << 30;

   typedef logic [30:0] cos_rom_type [COS_QUARTER + 1];

   // taylor series up to x^12, each term truncated, clamped to [0, 1]
   function automatic cos_rom_type build_cos_rom();
      cos_rom_type rom;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      longint      sum;
      for (int k = 0; k <= COS_QUARTER; k++) begin
         x   = (64'(k) * TWO_PI_Q30) >> COS_TABLE_BITS;
         x2  = (x * x) >> 30;
         sum = longint'(ONE_Q30);
         t   = ONE_Q30;
         t   = ((t * x2) >> 30) / 64'd2;
         sum = sum - longint'(t);
         t   = ((t * x2) >> 30) / 64'd12;
         sum = sum + longint'(t);
         t   = ((t * x2) >> 30) / 64'd30;
         sum = sum - longint'(t);
         t   = ((t * x2) >> 30) / 64'd56;
         sum = sum + longint'(t);
         t   = ((t * x2) >> 30) / 64'd90;
         sum = sum - longint'(t);
         t   = ((t * x2) >> 30) / 64'd132;
         sum = sum + longint'(t);
         if (sum < 0) begin
            sum = 0;
         end
         if (sum > longint'(ONE_Q30)) begin
            sum = longint'(ONE_Q30);
         end
         rom[k] = 31'(sum);
      end
      return rom;
   endfunction

   localparam cos_rom_type COS_ROM = build_cos_rom();

   // sequencer to oscillator controls
   typedef struct packed {
      logic load;
      logic advance;
   } lfo_ctrl_type;

endpackage

// ----- hdl/vdl_if.sv -----
interface vdl_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [vdl_pkg::SAMPLE_W-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

interface vdl_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [vdl_pkg::SAMPLE_W-1:0] sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

// ----- hdl/vdl_ram.sv -----
module vdl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/vdl_lfo.sv -----
module vdl_lfo (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [vdl_pkg::PHASE_W-1:0]    lfo_step,
   input  vdl_pkg::lfo_ctrl_type          ctrl,
   output logic [vdl_pkg::WEIGHT_W-1:0]   weight
);

   localparam int B = vdl_pkg::COS_TABLE_BITS;
   localparam logic [B-1:0] K_HALF    = B'(2 ** (B - 1));
   localparam logic [B-1:0] K_QUARTER = B'(2 ** (B - 2));
   localparam logic [31:0]  W_ONE     = 32'd1 << 30;
   localparam logic [31:0]  W_ROUND   = 32'd1 << 14;
   localparam logic [vdl_pkg::COUNT_W-1:0] COUNT_LAST =
      vdl_pkg::COUNT_W'(vdl_pkg::SAMPLE_RATE - 1);

   logic [vdl_pkg::PHASE_W-1:0]  phase_ff;
   logic [vdl_pkg::COUNT_W-1:0]  count_ff;
   logic [vdl_pkg::WEIGHT_W-1:0] weight_ff;

   logic [B-1:0]                  k_raw;
   logic [B-1:0]                  k_half;
   logic [B-1:0]                  k_fold;
   logic                          neg;
   logic [30:0]                   cos_q30;
   logic [31:0]                   w_full;

   // fold the phase index onto a quarter wave
   always_comb begin
      k_raw  = phase_ff[vdl_pkg::PHASE_W-1 -: B];
      k_half = (k_raw > K_HALF) ? (~k_raw + B'(1)) : k_raw;
      neg    = (k_half > K_QUARTER);
      k_fold = neg ? (K_HALF - k_half) : k_half;
   end

   // raised cosine weight, Q16, rounded
   always_comb begin
      cos_q30 = vdl_pkg::COS_ROM[k_fold[vdl_pkg::COS_IDX_W-1:0]];
      if (neg) begin
         w_full = W_ONE + {1'b0, cos_q30} + W_ROUND;
      end else begin
         w_full = W_ONE - {1'b0, cos_q30} + W_ROUND;
      end
   end

   // weight capture at request start
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         weight_ff <= w_full[31:15];
      end
   end

   // phase accumulator with once-per-second restart
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         count_ff <= '0;
      end else if (ctrl.advance) begin
         if (count_ff == COUNT_LAST) begin
            phase_ff <= '0;
            count_ff <= '0;
         end else begin
            phase_ff <= phase_ff + lfo_step;
            count_ff <= count_ff + vdl_pkg::COUNT_W'(1);
         end
      end
   end

   assign weight = weight_ff;

endmodule

// ----- hdl/vibrato_delay_line_core.sv -----
// Vibrato core: each request carries one signed 16-bit sample and yields one
// response sample read from a circular delay line whose delay follows a
// raised-cosine oscillator, blended between two neighboring taps, scaled by
// gain and saturated. An accepted request runs through the sequencer:
// oscillator weight, delay multiply, two reads through the single read port
// of the delay-line memory, tap blend, gain multiply and saturation. Its
// response enters the output register once that register is free, and the
// next request is taken in the cycle after that, so no new sample is taken
// before the last is through. Entries not yet written since reset read as
// zero through a fill pointer, so there is no clearing pass after reset.
// Registers: 0 depth (Q.8, clamped to line length minus one), 1 gain (Q2.14),
// 2 lfo_step (2^-32 turns per sample).
module vibrato_delay_line_core (
   input  logic                            clock,
   input  logic                            reset,
   vdl_req_if.sink                         req_if,
   vdl_rsp_if.source                       rsp_if,
   input  logic                            csr_wr_en,
   input  logic [vdl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [vdl_pkg::CSR_W-1:0]       csr_wdata
);

   localparam int AW = vdl_pkg::ADDR_W;
   localparam int TW = vdl_pkg::ADDR_W + 2;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_VD   = 3'd1;
   localparam logic [2:0] ST_RA   = 3'd2;
   localparam logic [2:0] ST_RB   = 3'd3;
   localparam logic [2:0] ST_MIX  = 3'd4;
   localparam logic [2:0] ST_PROD = 3'd5;
   localparam logic [2:0] ST_OUT  = 3'd6;

   localparam logic [TW-1:0] LEN      = TW'(vdl_pkg::LINE_DEPTH);
   localparam logic [TW-1:0] LEN2     = TW'(2 * vdl_pkg::LINE_DEPTH);
   localparam logic [TW-1:0] OFS_A    = TW'(2 * vdl_pkg::LINE_DEPTH - 2);
   localparam logic [TW-1:0] OFS_B    = TW'(2 * vdl_pkg::LINE_DEPTH - 3);
   localparam logic [AW-1:0] WP_LAST  = AW'(vdl_pkg::LINE_DEPTH - 1);
   localparam logic signed [20:0] SAT_HI = 21'sd32767;
   localparam logic signed [20:0] SAT_LO = -21'sd32768;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   logic [vdl_pkg::DEPTH_W-1:0]  depth_ff;
   logic [vdl_pkg::GAIN_W-1:0]   gain_ff;
   logic [vdl_pkg::PHASE_W-1:0]  lfo_step_ff;

   logic [AW-1:0]                wp_ff;
   logic                         full_ff;
   logic [vdl_pkg::SAMPLE_W-1:0] sample_ff;
   logic [vdl_pkg::DEPTH_W-1:0]  vd_ff;
   logic                         rd_ok_ff;
   logic signed [vdl_pkg::SAMPLE_W-1:0] tap_a_ff;
   logic signed [vdl_pkg::MIX_W-1:0]    mix_ff;
   logic signed [vdl_pkg::PROD_W-1:0]   prod_ff;
   logic                                rsp_valid_ff;
   logic signed [vdl_pkg::SAMPLE_W-1:0] rsp_data_ff;

   logic [vdl_pkg::WEIGHT_W-1:0] weight;
   vdl_pkg::lfo_ctrl_type        lfo_ctrl;
   logic [vdl_pkg::DEPTH_W+vdl_pkg::WEIGHT_W-1:0] vd_prod;
   logic [vdl_pkg::DEPTH_W-1:0]  depth_wr;

   logic [TW-1:0]                tap_sum;
   logic [AW-1:0]                rd_addr;
   logic [vdl_pkg::SAMPLE_W-1:0] rd_data;
   logic signed [vdl_pkg::SAMPLE_W-1:0] tap_b;
   logic [7:0]                   frac;
   logic signed [9:0]            wt_a;
   logic signed [9:0]            wt_b;
   logic signed [vdl_pkg::MIX_W-1:0] mix_in;
   logic signed [20:0]           rounded;
   logic signed [vdl_pkg::SAMPLE_W-1:0] sat_val;
   logic                         req_take;
   logic                         out_load;

   // configuration registers, depth clamped to line length minus one
   always_comb begin
      depth_wr = csr_wdata[vdl_pkg::DEPTH_W-1:0];
      if (32'(depth_wr) > vdl_pkg::DEPTH_LIMIT) begin
         depth_wr = vdl_pkg::DEPTH_LIMIT[vdl_pkg::DEPTH_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff    <= '0;
         gain_ff     <= vdl_pkg::GAIN_RESET;
         lfo_step_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            vdl_pkg::CSR_DEPTH:    depth_ff    <= depth_wr;
            vdl_pkg::CSR_GAIN:     gain_ff     <= csr_wdata[vdl_pkg::GAIN_W-1:0];
            vdl_pkg::CSR_LFO_STEP: lfo_step_ff <= csr_wdata[vdl_pkg::PHASE_W-1:0];
            default: ;
         endcase
      end
   end

   // handshakes
   assign req_if.ready = (state_ff == ST_IDLE) && !reset;
   assign req_take     = req_if.valid && req_if.ready;
   assign out_load     = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_if.ready);

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_take) state_in = ST_VD;
         ST_VD:   state_in = ST_RA;
         ST_RA:   state_in = ST_RB;
         ST_RB:   state_in = ST_MIX;
         ST_MIX:  state_in = ST_PROD;
         ST_PROD: state_in = ST_OUT;
         ST_OUT:  if (out_load) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // oscillator
   assign lfo_ctrl.load    = req_take;
   assign lfo_ctrl.advance = (state_ff == ST_MIX);

   vdl_lfo u_lfo (
      .clock    (clock),
      .reset    (reset),
      .lfo_step (lfo_step_ff),
      .ctrl     (lfo_ctrl),
      .weight   (weight)
   );

   // modulated delay in Q.8
   assign vd_prod = depth_ff * weight;

   always_ff @(posedge clock) begin
      if (req_take) begin
         sample_ff <= req_if.sample_in;
      end
      if (state_ff == ST_VD) begin
         vd_ff <= vd_prod[vdl_pkg::DEPTH_W+15:16];
      end
   end

   // tap address modulo line length, tap a then tap b
   always_comb begin
      tap_sum = {2'b00, wp_ff} + ((state_ff == ST_RB) ? OFS_B : OFS_A)
                - TW'(vd_ff[vdl_pkg::DEPTH_W-1:8]);
      if (tap_sum >= LEN2) begin
         rd_addr = AW'(tap_sum - LEN2);
      end else if (tap_sum >= LEN) begin
         rd_addr = AW'(tap_sum - LEN);
      end else begin
         rd_addr = AW'(tap_sum);
      end
   end

   vdl_ram #(
      .WIDTH (vdl_pkg::SAMPLE_W),
      .DEPTH (vdl_pkg::LINE_DEPTH)
   ) u_line (
      .clock   (clock),
      .wr_en   (state_ff == ST_MIX),
      .wr_addr (wp_ff),
      .wr_data (sample_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // entries not yet written since reset read as zero
   always_ff @(posedge clock) begin
      rd_ok_ff <= full_ff || (rd_addr < wp_ff);
      if (state_ff == ST_RB) begin
         tap_a_ff <= rd_ok_ff ? $signed(rd_data) : '0;
      end
   end

   // write pointer and fill flag
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         full_ff <= 1'b0;
      end else if (state_ff == ST_MIX) begin
         if (wp_ff == WP_LAST) begin
            wp_ff   <= '0;
            full_ff <= 1'b1;
         end else begin
            wp_ff <= wp_ff + AW'(1);
         end
      end
   end

   // linear blend of the two taps, Q8
   always_comb begin
      tap_b  = rd_ok_ff ? $signed(rd_data) : '0;
      frac   = vd_ff[7:0];
      wt_b   = $signed({2'b00, frac});
      wt_a   = 10'sd256 - wt_b;
      mix_in = tap_a_ff * wt_a + tap_b * wt_b;
   end

   // gain, rounding and saturation
   always_comb begin
      rounded = prod_ff[vdl_pkg::PROD_W-1:22];
      if (rounded > SAT_HI) begin
         sat_val = SAT_HI[vdl_pkg::SAMPLE_W-1:0];
      end else if (rounded < SAT_LO) begin
         sat_val = SAT_LO[vdl_pkg::SAMPLE_W-1:0];
      end else begin
         sat_val = rounded[vdl_pkg::SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_MIX) begin
         mix_ff <= mix_in;
      end
      if (state_ff == ST_PROD) begin
         prod_ff <= mix_ff * $signed({1'b0, gain_ff}) + vdl_pkg::PROD_ROUND;
      end
      if (out_load) begin
         rsp_data_ff <= sat_val;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.sample_out = rsp_data_ff;

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
   import vdl_pkg::*;

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   vdl_req_if req_bus ();
   vdl_rsp_if rsp_bus ();

   vibrato_delay_line_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // unused register index, writes to it must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   // mirror of the block state
   logic signed [SAMPLE_W-1:0] line_mem [LINE_DEPTH];
   int                         wr_ptr;
   logic [PHASE_W-1:0]         osc_phase;
   int                         sec_count;
   logic [DEPTH_W-1:0]         cfg_depth;
   logic [GAIN_W-1:0]          cfg_gain;
   logic [PHASE_W-1:0]         cfg_step;

   logic signed [SAMPLE_W-1:0] expected_out [$];
   int                         mismatches;
   int                         send_idle_pct;
   int                         recv_idle_pct;
   int                         hold_cycles;

   // clock
   initial clock = 1'b0;
   always #4 clock = ~clock;

   // run limit
   initial begin
      #20_000_000;
      $display("Mismatches found");
      $finish;
   end

   task automatic reset_model();
      for (int i = 0; i < LINE_DEPTH; i++) begin
         line_mem[i] = '0;
      end
      wr_ptr    = 0;
      osc_phase = '0;
      sec_count = 0;
      cfg_depth = '0;
      cfg_gain  = GAIN_RESET;
      cfg_step  = '0;
   endtask

   // raised cosine weight in Q16 from the top bits of the phase
   function automatic logic [WEIGHT_W-1:0] raised_cos_weight(input logic [PHASE_W-1:0] phase);
      int unsigned span;
      int unsigned k;
      bit          neg;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      longint      acc;
      longint      c;
      longint      w;
      span = 1 << COS_TABLE_BITS;
      k    = phase >> (PHASE_W - COS_TABLE_BITS);
      neg  = 1'b0;
      // fold to a quarter wave
      if (k > span / 2) begin
         k = span - k;
      end
      if (k > span / 4) begin
         k   = span / 2 - k;
         neg = 1'b1;
      end
      x    = (64'(k) * TWO_PI_Q30) >> COS_TABLE_BITS;
      x2   = (x * x) >> 30;
      acc  = longint'(ONE_Q30);
      term = ONE_Q30;
      // taylor terms, each truncated
      for (int j = 1; j <= 6; j++) begin
         term = ((term * x2) >> 30) / 64'((2 * j - 1) * (2 * j));
         if (j % 2 == 1) begin
            acc = acc - longint'(term);
         end else begin
            acc = acc + longint'(term);
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      if (acc > longint'(ONE_Q30)) begin
         acc = longint'(ONE_Q30);
      end
      c = neg ? -acc : acc;
      w = longint'(ONE_Q30) - c + (64'sd1 <<< 14);
      return WEIGHT_W'(w >>> 15);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] line_tap(input int age);
      return line_mem[(wr_ptr + 2 * LINE_DEPTH - 1 - age) % LINE_DEPTH];
   endfunction

   // output for one accepted sample, then advance the state
   function automatic logic signed [SAMPLE_W-1:0] predict_vibrato(
         input logic signed [SAMPLE_W-1:0] sample);
      logic [WEIGHT_W-1:0]        weight;
      logic [63:0]                delay_q8;
      int                         whole;
      int                         frac;
      logic signed [SAMPLE_W-1:0] tap_a;
      logic signed [SAMPLE_W-1:0] tap_b;
      longint                     mix;
      longint                     prod;
      longint                     res;
      weight   = raised_cos_weight(osc_phase);
      delay_q8 = (64'(cfg_depth) * 64'(weight)) >> 16;
      whole    = int'(delay_q8 >> 8);
      frac     = int'(delay_q8[7:0]);
      tap_a    = line_tap(whole + 1);
      tap_b    = line_tap(whole + 2);
      mix      = longint'(tap_a) * (256 - frac) + longint'(tap_b) * frac;
      prod     = mix * longint'(cfg_gain) + (64'sd1 <<< 21);
      // floor shift gives round half up
      res      = prod >>> 22;
      if (res > 32767) begin
         res = 32767;
      end
      if (res < -32768) begin
         res = -32768;
      end
      // state update
      line_mem[wr_ptr] = sample;
      wr_ptr    = (wr_ptr + 1) % LINE_DEPTH;
      osc_phase = osc_phase + cfg_step;
      sec_count = sec_count + 1;
      if (sec_count >= SAMPLE_RATE) begin
         sec_count = 0;
         osc_phase = '0;
      end
      return SAMPLE_W'(res);
   endfunction

   // one request, with a random gap ahead of it
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] sample);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         req_bus.sample_in <= SAMPLE_W'($urandom);
      end
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.sample_in <= sample;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) begin
         @(posedge clock);
      end
      expected_out.push_back(predict_vibrato(sample));
   endtask

   // stop offering and wait for every pending response
   task automatic drain_responses();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_out.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_DEPTH: begin
            cfg_depth = (32'(data[DEPTH_W-1:0]) > DEPTH_LIMIT) ? DEPTH_W'(DEPTH_LIMIT)
                                                            : data[DEPTH_W-1:0];
         end
         CSR_GAIN:     cfg_gain = data[GAIN_W-1:0];
         CSR_LFO_STEP: cfg_step = data;
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic signed [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(0, 7))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return 16'sh0000;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   // fresh random settings, extremes included
   task automatic randomize_settings();
      case ($urandom_range(0, 4))
         0:       write_reg(CSR_DEPTH, '0);
         1:       write_reg(CSR_DEPTH, DEPTH_LIMIT);
         2:       write_reg(CSR_DEPTH, $urandom);
         default: write_reg(CSR_DEPTH, $urandom_range(0, DEPTH_LIMIT));
      endcase
      case ($urandom_range(0, 4))
         0:       write_reg(CSR_GAIN, '0);
         1:       write_reg(CSR_GAIN, 32'hFFFF);
         2:       write_reg(CSR_GAIN, 32'(GAIN_RESET));
         default: write_reg(CSR_GAIN, $urandom);
      endcase
      case ($urandom_range(0, 5))
         0:       write_reg(CSR_LFO_STEP, '0);
         1:       write_reg(CSR_LFO_STEP, 32'h8000_0000);
         2:       write_reg(CSR_LFO_STEP, 32'hFFFF_FFFF);
         3:       write_reg(CSR_LFO_STEP, $urandom);
         default: write_reg(CSR_LFO_STEP, $urandom_range(1, 1 << 24));
      endcase
      if ($urandom_range(0, 3) == 0) begin
         write_reg(CSR_UNUSED, $urandom);
      end
   endtask

   // extremes, saturation, rounding and the open cases
   task automatic test_directed();
      // default settings pass the sample from two requests back
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      send_sample(16'sh0000);
      send_sample(-16'sd1);
      send_sample(16'sd1);
      send_sample(16'sh5555);
      send_sample(16'shAAAA);
      drain_responses();
      // full gain saturates both ways
      write_reg(CSR_GAIN, 32'hFFFF);
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      send_sample(16'sh0001);
      drain_responses();
      write_reg(CSR_GAIN, '0);
      send_sample(16'sh1234);
      drain_responses();
      // half gain; the odd sample 1 from two requests back lands on a half
      write_reg(CSR_GAIN, 32'd8192);
      send_sample(16'sd3);
      send_sample(-16'sd3);
      drain_responses();
      // unknown index is ignored, oversized depth clamps, upper bits dropped
      write_reg(CSR_UNUSED, 32'hFFFF_FFFF);
      write_reg(CSR_GAIN, 32'hFFFF_4000);
      write_reg(CSR_DEPTH, 32'hFFFF_FFFF);
      write_reg(CSR_LFO_STEP, 32'h8000_0000);
      send_sample(16'sh4000);
      send_sample(-16'sd200);
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      drain_responses();
      // fractional delay between taps
      write_reg(CSR_DEPTH, 32'h0000_0280);
      write_reg(CSR_LFO_STEP, 32'h4000_0000);
      send_sample(16'sd1000);
      send_sample(-16'sd777);
      send_sample(16'sd31);
      send_sample(16'sh7F00);
      drain_responses();
      write_reg(CSR_LFO_STEP, 32'hFFFF_FFFF);
      send_sample(16'sh0101);
      send_sample(16'shFEFE);
      drain_responses();
   endtask

   // random samples under several random settings
   task automatic test_random_stream(input int blocks);
      for (int b = 0; b < blocks; b++) begin
         randomize_settings();
         repeat (92) send_sample(random_sample());
         drain_responses();
      end
   endtask

   // long output stall while requests keep coming
   task automatic test_output_stall();
      randomize_settings();
      hold_cycles = 300;
      repeat (40) send_sample(random_sample());
      drain_responses();
   endtask

   // response ready, with random idling and a counted hold-off
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles = hold_cycles - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // compare each response with the oldest expected sample
   always @(posedge clock) begin : check_output
      logic signed [SAMPLE_W-1:0] want;
      if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (expected_out.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %0d", $time,
                     rsp_bus.sample_out);
            mismatches++;
         end else begin
            want = expected_out.pop_front();
            if (rsp_bus.sample_out !== want) begin
               $display("%0t: sample_out mismatch, expected %0d, actual %0d", $time,
                        want, rsp_bus.sample_out);
               mismatches++;
            end
         end
      end
   end

   initial begin
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;
      req_bus.valid     = 1'b0;
      req_bus.sample_in = '0;
      rsp_bus.ready     = 1'b0;
      mismatches        = 0;
      hold_cycles       = 0;
      send_idle_pct     = 33;
      recv_idle_pct     = 57;
      reset_model();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_stream(4);
      send_idle_pct = 57;
      recv_idle_pct = 33;
      test_random_stream(4);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_stream(4);
      test_output_stall();

      drain_responses();
      repeat (16) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
